FILE: design/vcdi_pkg.sv
package vcdi_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NCORNER        = 8;
    localparam int OUT_BITS       = 23;
    localparam int OUT_FRAC       = 16;
    localparam int OUT_MAX        = 2147483;
    localparam int SCALE_DIV      = 1000;
    localparam int SCALE_BITS     = 10;

    // offset of each corner, bit 0 x, bit 1 y, bit 2 z, in stream order
    localparam logic [2:0] CORNER_OFF [NCORNER] = '{
        3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
    };

endpackage

FILE: design/vcdi_sqrt.sv
module vcdi_sqrt #(
    parameter int FRAC_BITS = vcdi_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 8 * vcdi_pkg::VALUE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2*FRAC_BITS+1:0]  i_sq [vcdi_pkg::NCORNER],
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [FRAC_BITS:0]      o_root [vcdi_pkg::NCORNER],
    output logic [SIDE_W-1:0]       o_side
);
    import vcdi_pkg::*;

    localparam int SQW = 2 * FRAC_BITS + 2;
    localparam int RW  = FRAC_BITS + 1;
    localparam int TW  = 2 * FRAC_BITS + 3;

    logic [SQW-1:0]    r_rem  [RW][NCORNER];
    logic [RW-1:0]     r_res  [RW][NCORNER];
    logic [SIDE_W-1:0] r_side [RW];
    logic [RW-1:0]     r_v;

    logic [SQW-1:0]    w_rem  [RW][NCORNER];
    logic [RW-1:0]     w_res  [RW][NCORNER];
    logic [SIDE_W-1:0] w_side [RW];
    logic [RW-1:0]     w_v;

    genvar k, c;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            localparam int BIT = RW - 1 - k;
            if (k == 0) begin : g_first
                for (c = 0; c < NCORNER; c++) begin : g_in
                    assign w_rem[k][c] = i_sq[c];
                    assign w_res[k][c] = '0;
                end
                assign w_side[k] = i_side;
                assign w_v[k]    = i_valid;
            end else begin : g_next
                for (c = 0; c < NCORNER; c++) begin : g_in
                    assign w_rem[k][c] = r_rem[k-1][c];
                    assign w_res[k][c] = r_res[k-1][c];
                end
                assign w_side[k] = r_side[k-1];
                assign w_v[k]    = r_v[k-1];
            end

            for (c = 0; c < NCORNER; c++) begin : g_lane
                logic [TW-1:0] trial;
                logic          ge;
                always_comb begin
                    trial = (TW'(w_res[k][c]) << (BIT + 1)) + (TW'(1) << (2 * BIT));
                    ge    = TW'(w_rem[k][c]) >= trial;
                end
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k][c] <= ge ? SQW'(TW'(w_rem[k][c]) - trial) : w_rem[k][c];
                        r_res[k][c] <= ge ? (w_res[k][c] | (RW'(1) << BIT)) : w_res[k][c];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[k] <= w_side[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= w_v[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[RW-1];
    assign o_root  = r_res[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

FILE: design/vcdi_div.sv
module vcdi_div #(
    parameter int QW = vcdi_pkg::VALUE_BITS_DEF + 7,
    parameter int DW = vcdi_pkg::FRAC_BITS_DEF + 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_acc,
    input  logic [DW-1:0] i_den,
    input  logic          i_neg,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic          o_neg
);
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_acc [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_neg;
    logic [QW-1:0] r_v;

    logic [DW-1:0] w_rem [QW];
    logic [QW-1:0] w_acc [QW];
    logic [DW-1:0] w_den [QW];
    logic [QW-1:0] w_neg;
    logic [QW-1:0] w_v;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [DW:0] tmp;
            logic [DW:0] diff;
            logic        ge;

            if (k == 0) begin : g_first
                assign w_rem[k] = i_rem;
                assign w_acc[k] = i_acc;
                assign w_den[k] = i_den;
                assign w_neg[k] = i_neg;
                assign w_v[k]   = i_valid;
            end else begin : g_next
                assign w_rem[k] = r_rem[k-1];
                assign w_acc[k] = r_acc[k-1];
                assign w_den[k] = r_den[k-1];
                assign w_neg[k] = r_neg[k-1];
                assign w_v[k]   = r_v[k-1];
            end

            always_comb begin
                tmp  = {w_rem[k], w_acc[k][QW-1]};
                diff = tmp - {1'b0, w_den[k]};
                ge   = tmp >= {1'b0, w_den[k]};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[DW-1:0] : tmp[DW-1:0];
                    r_acc[k] <= {w_acc[k][QW-2:0], ge};
                    r_den[k] <= w_den[k];
                    r_neg[k] <= w_neg[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= w_v[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_acc[QW-1];
    assign o_neg   = r_neg[QW-1];

endmodule

FILE: design/vcdi_skid.sv
module vcdi_skid #(
    parameter int W = vcdi_pkg::OUT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_en,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);
    logic         r_out_v;
    logic [W-1:0] r_out;
    logic         r_sk_v;
    logic [W-1:0] r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (i_ready) begin
                r_sk_v <= 1'b0;
            end
        end else if (!r_out_v || i_ready) begin
            r_out_v <= i_valid;
        end else if (i_valid) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (i_ready) begin
                r_out <= r_sk;
            end
        end else if (!r_out_v || i_ready) begin
            r_out <= i_data;
        end else begin
            r_sk <= i_data;
        end
    end

    assign o_en    = !r_sk_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

FILE: design/voxel_corner_distance_interpolator.sv
// channel  | dir | fields (lowest bit up)
// s        | in  | frac_x, frac_y, frac_z, corner_000, _100, _110, _010, _001, _101, _111, _011
// m        | out | intensity
//
// One item per cycle while the output skid register is not full; the path runs through
// the bit-per-stage square root lanes, the bit-per-stage divider and the output register.
// Reset clears only valid bits.
// A full output skid register freezes every stage; nothing is dropped or repeated.
module voxel_corner_distance_interpolator #(
    parameter int VALUE_BITS = vcdi_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = vcdi_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // frac_x, frac_y, frac_z, corner_000, 100, 110, 010, 001, 101, 111, 011
    input  logic [((3*FRAC_BITS+8*VALUE_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // intensity
    output logic [((vcdi_pkg::OUT_BITS+7)/8)*8-1:0] o_m_tdata
);
    import vcdi_pkg::*;

    localparam int VB   = VALUE_BITS;
    localparam int FB   = FRAC_BITS;
    localparam int CW   = FB + 1;
    localparam int SQW  = 2 * FB + 2;
    localparam int RW   = FB + 1;
    localparam int PW   = VB + RW + 1;
    localparam int WW   = FB + 4;
    localparam int VSW  = VB + FB + 4;
    localparam int MW   = VB + FB + 3;
    localparam int QW   = VB + 7;
    localparam int DW   = FB + 14;
    localparam int NW   = MW + OUT_FRAC + 1;
    localparam int XW   = QW + OUT_BITS;
    localparam int OTW  = ((OUT_BITS + 7) / 8) * 8;

    logic en;

    // stage 1: components toward the opposite corners
    logic [CW-1:0] r1_c [NCORNER][3];
    logic [VB-1:0] r1_val [NCORNER];
    logic          r1_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCORNER; c++) begin
                for (int d = 0; d < 3; d++) begin
                    r1_c[c][d] <= CORNER_OFF[c][d] ? {1'b0, i_s_tdata[d*FB +: FB]}
                                : ((CW'(1) << FB) - {1'b0, i_s_tdata[d*FB +: FB]});
                end
                r1_val[c] <= i_s_tdata[3*FB + c*VB +: VB];
            end
        end
    end

    // stage 2: squares
    logic [2*CW-1:0] r2_sq [NCORNER][3];
    logic [VB-1:0]   r2_val [NCORNER];
    logic            r2_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCORNER; c++) begin
                for (int d = 0; d < 3; d++) begin
                    r2_sq[c][d] <= r1_c[c][d] * r1_c[c][d];
                end
                r2_val[c] <= r1_val[c];
            end
        end
    end

    // stage 3: squared distances
    logic [SQW-1:0]      r3_sq [NCORNER];
    logic [8*VB-1:0]     r3_vals;
    logic                r3_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCORNER; c++) begin
                r3_sq[c] <= SQW'(r2_sq[c][0]) + SQW'(r2_sq[c][1]) + SQW'(r2_sq[c][2]);
                r3_vals[c*VB +: VB] <= r2_val[c];
            end
        end
    end

    logic            sq_v;
    logic [RW-1:0]   sq_root [NCORNER];
    logic [8*VB-1:0] sq_vals;

    vcdi_sqrt #(
        .FRAC_BITS (FB),
        .SIDE_W    (8 * VB)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_sq    (r3_sq),
        .i_side  (r3_vals),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_vals)
    );

    // stage 4: weighted values
    logic signed [PW-1:0] r4_p [NCORNER];
    logic [RW-1:0]        r4_w [NCORNER];
    logic                 r4_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCORNER; c++) begin
                r4_p[c] <= $signed(sq_vals[c*VB +: VB]) * $signed({1'b0, sq_root[c]});
                r4_w[c] <= sq_root[c];
            end
        end
    end

    // stage 5: pair sums
    logic signed [VSW-1:0] r5_p [4];
    logic [WW-1:0]         r5_w [4];
    logic                  r5_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r5_p[j] <= VSW'(r4_p[2*j]) + VSW'(r4_p[2*j+1]);
                r5_w[j] <= WW'(r4_w[2*j]) + WW'(r4_w[2*j+1]);
            end
        end
    end

    // stage 6: totals
    logic signed [VSW-1:0] r6_vsum;
    logic [WW-1:0]         r6_wsum;
    logic                  r6_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_vsum <= r5_p[0] + r5_p[1] + r5_p[2] + r5_p[3];
            r6_wsum <= r5_w[0] + r5_w[1] + r5_w[2] + r5_w[3];
        end
    end

    // stage 7: divisor, magnitude
    logic [DW-1:0] r7_den;
    logic [MW-1:0] r7_mag;
    logic          r7_neg;
    logic          r7_v;
    logic [VSW-1:0] neg_vsum;

    assign neg_vsum = -r6_vsum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_den <= r6_wsum * SCALE_BITS'(SCALE_DIV);
            r7_neg <= r6_vsum[VSW-1];
            r7_mag <= r6_vsum[VSW-1] ? neg_vsum[MW-1:0] : r6_vsum[MW-1:0];
        end
    end

    logic [NW-1:0] dividend;
    logic          dv_v;
    logic [QW-1:0] dv_q;
    logic          dv_neg;

    assign dividend = {r7_mag, (OUT_FRAC + 1)'(0)};

    vcdi_div #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_rem   (DW'(dividend[NW-1:QW])),
        .i_acc   (dividend[QW-1:0]),
        .i_den   (r7_den),
        .i_neg   (r7_neg),
        .o_valid (dv_v),
        .o_quot  (dv_q),
        .o_neg   (dv_neg)
    );

    // stage 8: round half away, saturate, sign
    logic [XW-1:0]       half;
    logic [XW-1:0]       sat;
    logic [OUT_BITS-1:0] r8_out;
    logic                r8_v;

    always_comb begin
        half = (XW'(dv_q) + XW'(1)) >> 1;
        sat  = (half > XW'(OUT_MAX)) ? XW'(OUT_MAX) : half;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_out <= dv_neg ? -sat[OUT_BITS-1:0] : sat[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= sq_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= dv_v;
        end
    end

    logic [OUT_BITS-1:0] out_data;

    vcdi_skid #(
        .W (OUT_BITS)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r8_v),
        .i_data  (r8_out),
        .o_en    (en),
        .o_valid (o_m_tvalid),
        .o_data  (out_data),
        .i_ready (i_m_tready)
    );

    assign o_s_tready = en;
    assign o_m_tdata  = OTW'(out_data);

endmodule
